>>> hw/rtl/http_request_head_tokenizer_macros.svh
// Assertion macros for the HTTP request head tokenizer.
// Used by hrht_classifier; no other dependencies.
`ifndef HTTP_REQUEST_HEAD_TOKENIZER_MACROS_SVH
`define HTTP_REQUEST_HEAD_TOKENIZER_MACROS_SVH
`ifndef SYNTHESIS
`define HRHT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("hrht assertion failed");
`define HRHT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("hrht assertion failed");
`else
`define HRHT_ASSERT(lbl, clk, rstn, prop)
`define HRHT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> hw/rtl/hrht_pkg.sv
// Shared types and constants for the HTTP request head tokenizer.
// No dependencies.
package hrht_pkg;

  localparam int unsigned PosBits = 12;
  localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};
  localparam logic [7:0] CountMax = 8'hFF;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;

  typedef enum logic [2:0] {
    TcDelim   = 3'd0,
    TcMethod  = 3'd1,
    TcPath    = 3'd2,
    TcVersion = 3'd3,
    TcKey     = 3'd4,
    TcValue   = 3'd5
  } token_class_e;

  typedef enum logic [1:0] {
    StBusy  = 2'd0,
    StDone  = 2'd1,
    StError = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0]         out_byte;
    token_class_e       token_class;
    logic               field_start;
    logic [PosBits-1:0] char_position;
    logic [7:0]         header_number;
    status_e            status;
  } result_t;

endpackage

>>> hw/rtl/hrht_classifier.sv
// Parse state machine and result register of the tokenizer.
// Depends on hrht_pkg and the tokenizer assertion macros.
`include "http_request_head_tokenizer_macros.svh"
module hrht_classifier import hrht_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       ld_i,
  input  logic [7:0] byte_i,
  output result_t    res_o
);

  typedef enum logic [3:0] {
    PsMethod    = 4'd0,
    PsPath      = 4'd1,
    PsVersion   = 4'd2,
    PsReqLf     = 4'd3,
    PsLineStart = 4'd4,
    PsKey       = 4'd5,
    PsValueSkip = 4'd6,
    PsValue     = 4'd7,
    PsValueLf   = 4'd8,
    PsEndLf     = 4'd9
  } parse_state_e;

  parse_state_e       state_q, state_d, next_st;
  logic [PosBits-1:0] pos_q, pos_d;
  logic [7:0]         hdr_q, hdr_d;
  result_t            res_q, res_d;
  token_class_e       cls;
  status_e            st;
  logic               token;
  logic               hdr_inc;

  always_comb begin
    cls     = TcDelim;
    st      = StBusy;
    next_st = state_q;
    token   = 1'b0;
    hdr_inc = 1'b0;
    unique case (state_q)
      PsMethod: begin
        if (byte_i == ChSpace) next_st = PsPath;
        else begin cls = TcMethod; token = 1'b1; end
      end
      PsPath: begin
        if (byte_i == ChSpace) next_st = PsVersion;
        else begin cls = TcPath; token = 1'b1; end
      end
      PsVersion: begin
        if (byte_i == ChCr) next_st = PsReqLf;
        else begin cls = TcVersion; token = 1'b1; end
      end
      PsReqLf, PsValueLf: begin
        if (byte_i == ChLf) begin
          hdr_inc = (state_q == PsValueLf);
          next_st = PsLineStart;
        end else begin
          st = StError;
        end
      end
      PsLineStart: begin
        if (byte_i == ChCr) next_st = PsEndLf;
        else if (byte_i == ChLf) st = StError;
        else if (byte_i == ChColon) next_st = PsValueSkip;
        else begin cls = TcKey; token = 1'b1; next_st = PsKey; end
      end
      PsKey: begin
        if (byte_i == ChColon) next_st = PsValueSkip;
        else if (byte_i == ChCr || byte_i == ChLf) st = StError;
        else begin cls = TcKey; token = 1'b1; end
      end
      PsValueSkip: begin
        if (byte_i == ChSpace) next_st = PsValueSkip;
        else if (byte_i == ChCr) next_st = PsValueLf;
        else begin cls = TcValue; token = 1'b1; next_st = PsValue; end
      end
      PsValue: begin
        if (byte_i == ChCr) next_st = PsValueLf;
        else begin cls = TcValue; token = 1'b1; end
      end
      PsEndLf: begin
        st = (byte_i == ChLf) ? StDone : StError;
      end
      default: st = StError;
    endcase

    res_d.out_byte      = byte_i;
    res_d.token_class   = cls;
    res_d.field_start   = token && (pos_q == '0);
    res_d.char_position = token ? pos_q : '0;
    res_d.header_number = hdr_q;
    res_d.status        = st;

    if (!token) pos_d = '0;
    else if (pos_q < PosMax) pos_d = pos_q + 1'b1;
    else pos_d = pos_q;

    hdr_d = (hdr_inc && hdr_q < CountMax) ? hdr_q + 8'd1 : hdr_q;

    // restart after completion or error
    state_d = next_st;
    if (st != StBusy) begin
      state_d = PsMethod;
      pos_d   = '0;
      hdr_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PsMethod;
      pos_q   <= '0;
      hdr_q   <= '0;
      res_q   <= '0;
    end else if (ld_i) begin
      state_q <= state_d;
      pos_q   <= pos_d;
      hdr_q   <= hdr_d;
      res_q   <= res_d;
    end
  end

  assign res_o = res_q;

  `HRHT_ASSERT(a_restart_clears, clk_i, rst_ni,
    (ld_i && res_d.status != StBusy) |=> (state_q == PsMethod && hdr_q == 8'd0 && pos_q == '0))
  `HRHT_ASSERT(a_delim_zero_pos, clk_i, rst_ni,
    (ld_i && res_d.token_class == TcDelim) |=>
      (res_q.char_position == '0 && !res_q.field_start && pos_q == '0))
  `HRHT_ASSERT(a_hdr_monotonic, clk_i, rst_ni,
    (ld_i && res_d.status == StBusy) |=> (hdr_q >= $past(hdr_q)))

endmodule

>>> hw/rtl/http_request_head_tokenizer.sv
// HTTP request head tokenizer: an input register, the hrht_classifier
// state machine with its result register, and the stream handshake.
// Depends on hrht_pkg and hrht_classifier.
//
// Classifies one byte per clock unless m_axis_tready holds back the result; each byte passes through
// the input register and then the result register, and is checked and the parse state updated in the
// cycle it moves from the input register into the result register; s_axis_tready follows m_axis_tready
// combinationally when both registers are full. After a complete head or an error the parser restarts
// on the next byte.
module http_request_head_tokenizer import hrht_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte, [10:8] token_class, [11] field_start, [23:12] char_position,
  // [31:24] header_number, [33:32] status, [39:34] zero
  output logic [39:0] m_axis_tdata
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  logic       advance;
  result_t    res;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) in_byte_q <= s_axis_tdata;
  end

  hrht_classifier u_classifier (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ld_i   (advance),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, res.status, res.header_number, res.char_position,
                          res.field_start, res.token_class, res.out_byte};

endmodule

>>> bench/hrht_token_checker.sv
// Checker for the HTTP request head tokenizer: watches both stream channels,
// predicts the classification of every accepted byte and compares each result.
// Depends on hrht_pkg.
module hrht_token_checker import hrht_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [39:0]       m_axis_tdata,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    PsMethod,
    PsPath,
    PsVersion,
    PsReqLf,
    PsLineStart,
    PsKey,
    PsValueSkip,
    PsValue,
    PsValueLf,
    PsEndLf
  } parse_state_e;

  typedef struct packed {
    logic [7:0]         data;
    token_class_e       cls;
    logic               start;
    logic [PosBits-1:0] pos;
    logic [7:0]         hdr;
    status_e            st;
  } token_t;

  parse_state_e       state_q;
  logic [PosBits-1:0] field_pos_q;
  logic [7:0]         header_cnt_q;
  token_t             expected_tokens[$];
  int unsigned        fails;

  function automatic token_t classify_byte(input logic [7:0] b);
    token_t       t;
    parse_state_e nxt;
    logic         in_field;
    t.data   = b;
    t.cls    = TcDelim;
    t.st     = StBusy;
    t.hdr    = header_cnt_q;
    nxt      = state_q;
    in_field = 1'b0;
    case (state_q)
      PsMethod: begin
        if (b == ChSpace) nxt = PsPath;
        else begin t.cls = TcMethod; in_field = 1'b1; end
      end
      PsPath: begin
        if (b == ChSpace) nxt = PsVersion;
        else begin t.cls = TcPath; in_field = 1'b1; end
      end
      PsVersion: begin
        if (b == ChCr) nxt = PsReqLf;
        else begin t.cls = TcVersion; in_field = 1'b1; end
      end
      PsReqLf, PsValueLf: begin
        if (b == ChLf) begin
          if (state_q == PsValueLf && header_cnt_q != CountMax)
            header_cnt_q = header_cnt_q + 8'd1;
          nxt = PsLineStart;
        end else begin
          t.st = StError;
        end
      end
      PsLineStart: begin
        if (b == ChCr) nxt = PsEndLf;
        else if (b == ChLf) t.st = StError;
        else if (b == ChColon) nxt = PsValueSkip;
        else begin t.cls = TcKey; in_field = 1'b1; nxt = PsKey; end
      end
      PsKey: begin
        if (b == ChColon) nxt = PsValueSkip;
        else if (b == ChCr || b == ChLf) t.st = StError;
        else begin t.cls = TcKey; in_field = 1'b1; end
      end
      PsValueSkip: begin
        if (b == ChSpace) nxt = PsValueSkip;
        else if (b == ChCr) nxt = PsValueLf;
        else begin t.cls = TcValue; in_field = 1'b1; nxt = PsValue; end
      end
      PsValue: begin
        if (b == ChCr) nxt = PsValueLf;
        else begin t.cls = TcValue; in_field = 1'b1; end
      end
      PsEndLf: begin
        t.st = (b == ChLf) ? StDone : StError;
      end
      default: begin
        t.st = StError;
      end
    endcase
    if (in_field) begin
      t.start = (field_pos_q == '0);
      t.pos   = field_pos_q;
      if (field_pos_q != PosMax) field_pos_q = field_pos_q + 1'b1;
    end else begin
      t.start     = 1'b0;
      t.pos       = '0;
      field_pos_q = '0;
    end
    // completion and error both restart the parser
    if (t.st != StBusy) begin
      state_q      = PsMethod;
      field_pos_q  = '0;
      header_cnt_q = '0;
    end else begin
      state_q = nxt;
    end
    return t;
  endfunction

  task automatic check_token(input token_t e, input logic [39:0] d);
    if (d[7:0] !== e.data) begin
      $error("out_byte: expected %0d, got %0d", e.data, d[7:0]);
      fails++;
    end
    if (d[10:8] !== e.cls) begin
      $error("token_class: expected %0d, got %0d", e.cls, d[10:8]);
      fails++;
    end
    if (d[11] !== e.start) begin
      $error("field_start: expected %0d, got %0d", e.start, d[11]);
      fails++;
    end
    if (d[23:12] !== e.pos) begin
      $error("char_position: expected %0d, got %0d", e.pos, d[23:12]);
      fails++;
    end
    if (d[31:24] !== e.hdr) begin
      $error("header_number: expected %0d, got %0d", e.hdr, d[31:24]);
      fails++;
    end
    if (d[33:32] !== e.st) begin
      $error("status: expected %0d, got %0d", e.st, d[33:32]);
      fails++;
    end
  endtask

  initial fails = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      state_q      = PsMethod;
      field_pos_q  = '0;
      header_cnt_q = '0;
      expected_tokens.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_tokens.size() == 0) begin
          $error("result transfer with nothing expected, tdata %h", m_axis_tdata);
          fails++;
        end else begin
          check_token(expected_tokens.pop_front(), m_axis_tdata);
        end
      end
      if (s_axis_tvalid && s_axis_tready) expected_tokens.push_back(classify_byte(s_axis_tdata));
    end
    pending_o    <= expected_tokens.size();
    fail_count_o <= fails;
  end

endmodule

>>> bench/testbench.sv
// Top of the tokenizer bench: clock, reset, byte stimulus and result back-pressure
// around http_request_head_tokenizer, with hrht_token_checker judging the results.
// Depends on hrht_pkg, the tokenizer RTL and hrht_token_checker.
module testbench;
  import hrht_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1_500_000;
  localparam int unsigned RandomBytes = 1200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned sent_bytes = 0;
  int          stall_left = 0;
  logic        tx_steady = 1'b0;
  logic        rx_steady = 1'b0;

  always #6 clk_i = ~clk_i;

  http_request_head_tokenizer u_top (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  hrht_token_checker u_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
      rx_steady     <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) rx_steady <= !rx_steady;
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left    <= stall_left - 1;
      end else if (!rx_steady && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left    <= ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 2);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 15);
    if (tx_steady || r < 10) return 0;
    if (r < 15) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic logic [7:0] field_byte(input logic [7:0] x0, x1, x2);
    logic [7:0] b;
    do begin
      b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(33, 126));
    end while (b == x0 || b == x1 || b == x2);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_bytes++;
  endtask

  task automatic send_bytes(ref logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i]);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic push_field(ref logic [7:0] q[$], input int len, input logic [7:0] x0, x1, x2);
    for (int i = 0; i < len; i++) q.push_back(field_byte(x0, x1, x2));
  endtask

  task automatic build_request(ref logic [7:0] q[$], input int path_len, input int n_hdr,
                               input int max_len);
    q.delete();
    push_field(q, $urandom_range(0, max_len), ChSpace, ChSpace, ChSpace);
    q.push_back(ChSpace);
    push_field(q, path_len, ChSpace, ChSpace, ChSpace);
    q.push_back(ChSpace);
    push_field(q, $urandom_range(0, max_len), ChCr, ChCr, ChCr);
    q.push_back(ChCr);
    q.push_back(ChLf);
    repeat (n_hdr) begin
      push_field(q, $urandom_range(0, max_len), ChColon, ChCr, ChLf);
      q.push_back(ChColon);
      repeat ($urandom_range(0, 2)) q.push_back(ChSpace);
      push_field(q, $urandom_range(0, max_len), ChCr, ChCr, ChCr);
      q.push_back(ChCr);
      q.push_back(ChLf);
    end
    q.push_back(ChCr);
    q.push_back(ChLf);
  endtask

  function automatic logic [7:0] special_byte();
    case ($urandom_range(0, 4))
      0: return ChCr;
      1: return ChLf;
      2: return ChColon;
      3: return ChSpace;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic corrupt(ref logic [7:0] q[$]);
    int kind;
    int at;
    kind = $urandom_range(0, 9);
    at   = $urandom_range(0, q.size() - 1);
    if (kind == 6 || kind == 7) begin
      q[at] = special_byte();
    end else if (kind == 8) begin
      while (q.size() > at) void'(q.pop_back());
      repeat ($urandom_range(1, 6)) q.push_back(special_byte());
    end else if (kind == 9) begin
      q.delete();
      repeat ($urandom_range(1, 16)) q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    logic [7:0] q[$];
    int         random_start;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all field classes, byte extremes, skipped spaces, LF inside a value, completion
    q = '{8'h4D, ChSpace, 8'h00, ChSpace, 8'hFF, ChCr, ChLf, 8'h6B, ChColon, ChSpace, ChLf,
          8'h76, ChCr, ChLf, ChCr, ChLf};
    send_bytes(q);
    // empty method, path and version, empty key and value, then CR inside a key
    q = '{ChSpace, ChSpace, ChCr, ChLf, ChColon, ChCr, ChLf, 8'h6B, ChCr};
    send_bytes(q);
    // CR not followed by LF
    q = '{ChSpace, ChSpace, ChCr, ChCr};
    send_bytes(q);
    drain();

    // saturating char_position, then saturating header_number
    build_request(q, 4100, 0, 3);
    send_bytes(q);
    build_request(q, 2, 260, 2);
    send_bytes(q);

    random_start = sent_bytes;
    while (sent_bytes - random_start < RandomBytes) begin
      tx_steady = ($urandom_range(0, 4) == 0);
      build_request(q, $urandom_range(0, 6), $urandom_range(0, 4), 6);
      corrupt(q);
      send_bytes(q);
      if ($urandom_range(0, 15) == 0) drain();
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
